// ----- sv/smft_pkg.sv -----
// Shared types and constants of the sync marker format tally.
package smft_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int WIN_LEN       = 8;
   localparam int HIST_LEN      = WIN_LEN - 1;
   localparam int FILL_W        = $clog2(HIST_LEN + 1);

   localparam logic [7:0]  SYNC_BYTE = 8'hff;
   localparam logic [7:0]  ZERO_BYTE = 8'h00;
   localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;

   typedef struct packed {
      logic              valid;
      logic [15:0]       code;
      logic [31:0]       total;
      logic              found;
      logic              added;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       count;
   } token_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] value);
      sat_inc = (value == COUNT_MAX) ? value : value + 32'd1;
   endfunction

endpackage

// ----- sv/smft_req_if.sv -----
// Input channel: payload bytes with end-of-packet flag.
interface smft_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       packet_end;

   modport source (output valid, output data_byte, output packet_end, input ready);
   modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

// ----- sv/smft_rsp_if.sv -----
// Result channel: one tally report per detected marker.
interface smft_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] format_code;
   logic [4:0]  entry_index;
   logic [31:0] format_count;
   logic        new_entry;
   logic        dropped;
   logic [31:0] total_markers;

   modport source (output valid, output format_code, output entry_index,
                   output format_count, output new_entry, output dropped,
                   output total_markers, input ready);
   modport sink   (input valid, input format_code, input entry_index,
                   input format_count, input new_entry, input dropped,
                   input total_markers, output ready);
endinterface

// ----- sv/smft_window.sv -----
// Byte history, marker detection and marker total; issues one token per cycle while adv is high.
module smft_window (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  take,
   input  logic [7:0]            data_byte,
   input  logic                  packet_end,
   output smft_pkg::token_type   tok_out
);

   logic [7:0]                  hist_ff [smft_pkg::HIST_LEN];
   logic [smft_pkg::FILL_W-1:0] fill_ff;
   logic [smft_pkg::FILL_W-1:0] fill_in;
   logic [31:0]                 total_ff;
   logic [31:0]                 total_in;
   smft_pkg::token_type         tok_ff;
   smft_pkg::token_type         tok_in;
   logic                        marker;

   assign marker = take && (fill_ff == smft_pkg::FILL_W'(smft_pkg::HIST_LEN)) &&
                   (hist_ff[0] == smft_pkg::ZERO_BYTE) &&
                   (hist_ff[1] == smft_pkg::ZERO_BYTE) &&
                   (hist_ff[2] == smft_pkg::SYNC_BYTE) &&
                   (hist_ff[3] == smft_pkg::SYNC_BYTE);

   always_comb begin
      total_in = marker ? smft_pkg::sat_inc(total_ff) : total_ff;
      if (!take) begin
         fill_in = fill_ff;
      end else if (packet_end) begin
         fill_in = '0;
      end else if (fill_ff == smft_pkg::FILL_W'(smft_pkg::HIST_LEN)) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + 1'b1;
      end
      tok_in       = '0;
      tok_in.valid = marker;
      tok_in.code  = {data_byte, hist_ff[smft_pkg::HIST_LEN-1]};
      tok_in.total = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         total_ff     <= '0;
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         fill_ff  <= fill_in;
         total_ff <= total_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < smft_pkg::HIST_LEN - 1; i++) begin
            hist_ff[i] <= hist_ff[i+1];
         end
         hist_ff[smft_pkg::HIST_LEN-1] <= data_byte;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- sv/smft_cell.sv -----
// One table slot: holds a code and its count, updates the passing token.
module smft_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic [smft_pkg::SLOT_W-1:0] index,
   input  smft_pkg::token_type         tok_in,
   output smft_pkg::token_type         tok_out
);

   logic                valid_ff;
   logic [15:0]         code_ff;
   logic [31:0]         count_ff;
   logic [31:0]         count_inc;
   logic                hit;
   logic                alloc;
   smft_pkg::token_type tok_ff;
   smft_pkg::token_type tok_next;

   assign count_inc = smft_pkg::sat_inc(count_ff);
   assign hit   = tok_in.valid && !tok_in.found && valid_ff && (code_ff == tok_in.code);
   assign alloc = tok_in.valid && !tok_in.found && !valid_ff;

   always_comb begin
      tok_next = tok_in;
      if (hit) begin
         tok_next.found = 1'b1;
         tok_next.slot  = index;
         tok_next.count = count_inc;
      end else if (alloc) begin
         tok_next.found = 1'b1;
         tok_next.added = 1'b1;
         tok_next.slot  = index;
         tok_next.count = 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_next;
         if (alloc) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && hit) begin
         count_ff <= count_inc;
      end else if (adv && alloc) begin
         code_ff  <= tok_in.code;
         count_ff <= 32'd1;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- sv/sync_marker_format_tally.sv -----
// Top level: byte window feeding a chain of table cells.
// A marker's token is registered in the window, then in each table cell in turn, before it reaches the output.
// Throughput: one byte per cycle; each marker token moves one table cell per cycle.
// The whole chain stalls while a result waits at the output register.
// Reset (synchronous) clears the window, marker total and every slot's valid bit at once;
// no clearing pass follows, bytes are taken in the first cycle after reset.
module sync_marker_format_tally (
   input logic        clock,
   input logic        reset,
   smft_req_if.sink   req_ch,
   smft_rsp_if.source rsp_ch
);

   smft_pkg::token_type tok [smft_pkg::TABLE_ENTRIES + 1];
   logic                adv;
   logic [smft_pkg::SLOT_W+4:0] slot_ext;

   assign adv          = !tok[smft_pkg::TABLE_ENTRIES].valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   smft_window u_window (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .take       (req_ch.valid && adv),
      .data_byte  (req_ch.data_byte),
      .packet_end (req_ch.packet_end),
      .tok_out    (tok[0])
   );

   for (genvar i = 0; i < smft_pkg::TABLE_ENTRIES; i++) begin : g_cell
      smft_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .index   (smft_pkg::SLOT_W'(i)),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   assign slot_ext = {5'd0, tok[smft_pkg::TABLE_ENTRIES].slot};

   assign rsp_ch.valid         = tok[smft_pkg::TABLE_ENTRIES].valid;
   assign rsp_ch.format_code   = tok[smft_pkg::TABLE_ENTRIES].code;
   assign rsp_ch.entry_index   = slot_ext[4:0];
   assign rsp_ch.format_count  = tok[smft_pkg::TABLE_ENTRIES].count;
   assign rsp_ch.new_entry     = tok[smft_pkg::TABLE_ENTRIES].added;
   assign rsp_ch.dropped       = !tok[smft_pkg::TABLE_ENTRIES].found;
   assign rsp_ch.total_markers = tok[smft_pkg::TABLE_ENTRIES].total;

endmodule

// ----- sv/smft_checker.sv -----
// Port-level checks of the tally block, bound to the top level.
module smft_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] format_code,
   input logic [4:0]  entry_index,
   input logic [31:0] format_count,
   input logic        new_entry,
   input logic        dropped,
   input logic [31:0] total_markers
);

   a_reset_idle : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(format_code) && $stable(total_markers))
      else $error("stalled result changed");

   a_drop : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dropped |-> format_count == 32'd0 && entry_index == 5'd0 && !new_entry)
      else $error("dropped result carries slot data");

   a_new : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && new_entry |-> format_count == 32'd1 && !dropped)
      else $error("new entry count not one");

   a_kept : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !dropped |-> format_count != 32'd0 && total_markers != 32'd0)
      else $error("stored code with zero count");

endmodule

bind sync_marker_format_tally smft_checker u_smft_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .format_code   (rsp_ch.format_code),
   .entry_index   (rsp_ch.entry_index),
   .format_count  (rsp_ch.format_count),
   .new_entry     (rsp_ch.new_entry),
   .dropped       (rsp_ch.dropped),
   .total_markers (rsp_ch.total_markers)
);

// ----- tb/format_tally_scoreboard.sv -----
// Scoreboard: predicts the format tally from accepted bytes and checks each report.
module format_tally_scoreboard (
   input  logic clock,
   input  logic reset,
   smft_req_if  req_ch,
   smft_rsp_if  rsp_ch,
   output int   mismatches,
   output int   reports_pending
);
   import smft_pkg::*;

   typedef struct packed {
      logic [15:0] code;
      logic [4:0]  slot;
      logic [31:0] count;
      logic        added;
      logic        lost;
      logic [31:0] total;
   } tally_report_type;

   tally_report_type expected_reports[$];
   tally_report_type oldest_report;

   logic [7:0]  byte_window [WIN_LEN];
   int unsigned window_fill;
   logic [15:0] code_table [TABLE_ENTRIES];
   logic [31:0] count_table [TABLE_ENTRIES];
   int unsigned entries_used;
   logic [31:0] marker_total;

   task automatic tally_byte(input logic [7:0] value, input logic last);
      tally_report_type report;
      int               hit;
      if (window_fill < WIN_LEN) begin
         byte_window[window_fill] = value;
         window_fill++;
      end else begin
         for (int i = 0; i < WIN_LEN - 1; i++) byte_window[i] = byte_window[i + 1];
         byte_window[WIN_LEN - 1] = value;
      end
      if (window_fill == WIN_LEN && byte_window[0] == ZERO_BYTE && byte_window[1] == ZERO_BYTE
          && byte_window[2] == SYNC_BYTE && byte_window[3] == SYNC_BYTE) begin
         report = '0;
         report.code = {byte_window[7], byte_window[6]};
         if (marker_total != COUNT_MAX) marker_total++;
         report.total = marker_total;
         hit = -1;
         for (int i = 0; i < entries_used; i++) begin
            if (hit < 0 && code_table[i] == report.code) hit = i;
         end
         if (hit >= 0) begin
            if (count_table[hit] != COUNT_MAX) count_table[hit]++;
            report.slot  = 5'(hit);
            report.count = count_table[hit];
         end else if (entries_used < TABLE_ENTRIES) begin
            code_table[entries_used]  = report.code;
            count_table[entries_used] = 32'd1;
            report.slot  = 5'(entries_used);
            report.count = 32'd1;
            report.added = 1'b1;
            entries_used++;
         end else begin
            report.lost = 1'b1;
         end
         expected_reports.push_back(report);
      end
      if (last) begin
         foreach (byte_window[i]) byte_window[i] = ZERO_BYTE;
         window_fill = 0;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (byte_window[i]) byte_window[i] = ZERO_BYTE;
         foreach (code_table[i]) begin
            code_table[i]  = '0;
            count_table[i] = '0;
         end
         window_fill  = 0;
         entries_used = 0;
         marker_total = '0;
         mismatches   = 0;
         expected_reports.delete();
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: expected no report, actual report with format_code %0h",
                        $time, rsp_ch.format_code);
               mismatches++;
            end else begin
               oldest_report = expected_reports.pop_front();
               check_field("format_code", 32'(oldest_report.code), 32'(rsp_ch.format_code));
               check_field("entry_index", 32'(oldest_report.slot), 32'(rsp_ch.entry_index));
               check_field("format_count", oldest_report.count, rsp_ch.format_count);
               check_field("new_entry", 32'(oldest_report.added), 32'(rsp_ch.new_entry));
               check_field("dropped", 32'(oldest_report.lost), 32'(rsp_ch.dropped));
               check_field("total_markers", oldest_report.total, rsp_ch.total_markers);
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            tally_byte(req_ch.data_byte, req_ch.packet_end);
      end
      reports_pending = expected_reports.size();
   end

endmodule

// ----- tb/testbench.sv -----
// Testbench top: drives payload packets with sync markers and reports the verdict.
module testbench;
   import smft_pkg::*;

   localparam int RANDOM_BYTES = 1950;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = TABLE_ENTRIES + 16;
   localparam int POOL_SIZE    = 48;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int          mismatches;
   int          reports_pending;
   logic [7:0]  packet_bytes[$];
   logic [15:0] code_pool [POOL_SIZE];

   smft_req_if req_ch();
   smft_rsp_if rsp_ch();

   sync_marker_format_tally dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   format_tally_scoreboard tally_check (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .mismatches      (mismatches),
      .reports_pending (reports_pending)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= value;
      req_ch.packet_end <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic send_packet();
      foreach (packet_bytes[i]) send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
   endtask

   task automatic add_sync_prefix();
      packet_bytes.push_back(ZERO_BYTE);
      packet_bytes.push_back(ZERO_BYTE);
      packet_bytes.push_back(SYNC_BYTE);
      packet_bytes.push_back(SYNC_BYTE);
   endtask

   task automatic build_packet();
      int unsigned pick;
      int unsigned keep;
      logic [15:0] code;
      packet_bytes.delete();
      repeat ($urandom_range(1, 4)) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            add_sync_prefix();
            packet_bytes.push_back(8'($urandom));
            packet_bytes.push_back(8'($urandom));
            code = ($urandom_range(99) < 85) ? code_pool[$urandom_range(POOL_SIZE - 1)]
                                             : 16'($urandom);
            packet_bytes.push_back(code[7:0]);
            packet_bytes.push_back(code[15:8]);
         end else if (pick < 70) begin
            add_sync_prefix();
         end else if (pick < 80) begin
            add_sync_prefix();
            repeat ($urandom_range(1, 3)) void'(packet_bytes.pop_back());
            packet_bytes.push_back(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6)) begin
               pick = $urandom_range(99);
               packet_bytes.push_back(pick < 30 ? ZERO_BYTE : pick < 50 ? SYNC_BYTE
                                                            : 8'($urandom));
            end
         end
      end
      // cut some packets short so markers are truncated at the packet boundary
      if ($urandom_range(99) < 15) begin
         keep = $urandom_range(1, packet_bytes.size());
         while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
      end
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int sent;
      req_ch.valid      = 1'b0;
      req_ch.data_byte  = '0;
      req_ch.packet_end = 1'b0;
      rsp_ch.ready      = 1'b0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      foreach (code_pool[i]) code_pool[i] = 16'($urandom);
      code_pool[0] = 16'h0000;
      code_pool[1] = 16'hffff;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      packet_bytes = '{8'h00};
      send_packet();
      packet_bytes = '{8'hff};
      send_packet();
      // overlapping markers, the second completing on the packet's last byte
      packet_bytes = '{8'h00, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00, 8'hff, 8'hff,
                       8'h00, 8'h00, 8'hff, 8'hff};
      send_packet();
      packet_bytes = '{8'h00, 8'h00, 8'hff, 8'hff, 8'h5a, 8'ha5, 8'h00, 8'h00,
                       8'h00, 8'h00, 8'hff, 8'hff};
      send_packet();
      packet_bytes = '{8'h80, 8'h01};
      send_packet();

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         case (sent * 4 / RANDOM_BYTES)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 51; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         build_packet();
         sent += packet_bytes.size();
         send_packet();
      end
      req_ch.valid <= 1'b0;

      while (reports_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
